/* design/sas_pkg.sv */
package sas_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [23:0] scatter_factor;
        logic               last_atom;
    } sas_in_t;

    typedef struct packed {
        logic signed [47:0] amp_real;
        logic signed [47:0] amp_imag;
        logic               saturated;
    } sas_out_t;

    // Phase word handed from front to back: raw Q28.38 sum plus payload
    typedef struct packed {
        logic signed [65:0] phase;
        logic signed [23:0] factor;
        logic               last;
    } sas_job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_QM,
        BK_WRAP,
        BK_ROT,
        BK_ACC
    } sas_bk_state_t;

    localparam int CORDIC_STEPS = 30;
    localparam int FIFO_DEPTH   = 4;
    localparam logic        [63:0] TWO_PI_Q38   = 64'd1727108826179;
    localparam logic signed [35:0] PI_Q30       = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30  = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30   = 36'sd6746518852;
    localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
    localparam logic signed [47:0] ACC_MAX      = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN      = 48'sh8000_0000_0000;
    localparam logic signed [24:0] TRIG_ONE     = 25'sd4194304;

    // Whole number of turns above 2^62: lifts any phase sum to a positive value
    localparam logic [63:0] PHASE_BIAS =
        ((64'd1 << 62) + TWO_PI_Q38 - 64'd1) / TWO_PI_Q38 * TWO_PI_Q38;
    // floor(2^72 / 2pi_Q38): turns estimate from the top 31 bits of the phase
    localparam logic [31:0] RECIP_Q72 = 32'((73'd1 << 72) / 73'(TWO_PI_Q38));

    localparam logic [1:0] REG_Q_X = 2'd0;
    localparam logic [1:0] REG_Q_Y = 2'd1;
    localparam logic [1:0] REG_Q_Z = 2'd2;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 30'd843314856;
            5'd1:  atan_q30 = 30'd497837829;
            5'd2:  atan_q30 = 30'd263043836;
            5'd3:  atan_q30 = 30'd133525158;
            5'd4:  atan_q30 = 30'd67021686;
            5'd5:  atan_q30 = 30'd33543515;
            5'd6:  atan_q30 = 30'd16775850;
            5'd7:  atan_q30 = 30'd8388437;
            5'd8:  atan_q30 = 30'd4194282;
            5'd9:  atan_q30 = 30'd2097149;
            5'd10: atan_q30 = 30'd1048575;
            5'd11: atan_q30 = 30'd524287;
            5'd12: atan_q30 = 30'd262143;
            5'd13: atan_q30 = 30'd131071;
            5'd14: atan_q30 = 30'd65535;
            5'd15: atan_q30 = 30'd32767;
            5'd16: atan_q30 = 30'd16383;
            5'd17: atan_q30 = 30'd8191;
            5'd18: atan_q30 = 30'd4095;
            5'd19: atan_q30 = 30'd2047;
            5'd20: atan_q30 = 30'd1023;
            5'd21: atan_q30 = 30'd511;
            5'd22: atan_q30 = 30'd255;
            5'd23: atan_q30 = 30'd127;
            5'd24: atan_q30 = 30'd63;
            5'd25: atan_q30 = 30'd31;
            5'd26: atan_q30 = 30'd15;
            5'd27: atan_q30 = 30'd7;
            5'd28: atan_q30 = 30'd3;
            5'd29: atan_q30 = 30'd1;
            default: atan_q30 = 30'd0;
        endcase
    endfunction

endpackage

/* design/sas_front.sv */
module sas_front
    import sas_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [31:0] q_x,
    input  logic signed [31:0] q_y,
    input  logic signed [31:0] q_z,
    input  logic               in_valid,
    output logic               in_ready,
    input  sas_in_t            in_word,
    output logic               job_valid,
    input  logic               job_ready,
    output sas_job_t           job_word
);

    // Stage 1: three products; stage 2: sum of floored terms
    logic               s1_valid_reg;
    logic signed [63:0] px_reg, py_reg, pz_reg;
    logic signed [23:0] f1_reg;
    logic               l1_reg;
    logic               s2_valid_reg;
    sas_job_t           s2_reg;
    logic               adv1, adv2;

    assign adv2     = !s2_valid_reg || job_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    // Advance the multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv1) begin
            s1_valid_reg <= in_valid;
        end
        if (adv1 && in_valid) begin
            px_reg <= in_word.pos_x * q_x;
            py_reg <= in_word.pos_y * q_y;
            pz_reg <= in_word.pos_z * q_z;
            f1_reg <= in_word.scatter_factor;
            l1_reg <= in_word.last_atom;
        end
    end

    // Advance the sum stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv2) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (adv2 && s1_valid_reg) begin
            s2_reg.phase  <= 66'(px_reg >>> 2) + 66'(py_reg >>> 2) + 66'(pz_reg >>> 2);
            s2_reg.factor <= f1_reg;
            s2_reg.last   <= l1_reg;
        end
    end

    assign job_valid = s2_valid_reg;
    assign job_word  = s2_reg;

endmodule

/* design/sas_fifo.sv */
module sas_fifo
    import sas_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  sas_job_t wr_word,
    output logic     rd_valid,
    input  logic     rd_ready,
    output sas_job_t rd_word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sas_job_t          mem_reg [DEPTH];
    logic [AW-1:0]     wp_reg, rp_reg;
    logic [AW:0]       cnt_reg;
    logic              push, pop;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_word  = mem_reg[rp_reg];

    // Hold queued words; wrap pointers at the depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) begin
            mem_reg[wp_reg] <= wr_word;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue count over depth");
    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> cnt_reg == $past(cnt_reg) - 1'b1) else $error("pop miscounted");
    a_push_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("push miscounted");
`endif

endmodule

/* design/sas_back.sv */
module sas_back
    import sas_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     job_valid,
    output logic     job_ready,
    input  sas_job_t job_word,
    output logic     out_valid,
    input  logic     out_ready,
    output sas_out_t out_word
);

    sas_bk_state_t      state_reg, state_next;
    logic [62:0]        r_reg;
    logic [22:0]        qe_reg;
    logic signed [35:0] z_reg;
    logic signed [33:0] x_reg, y_reg;
    logic [4:0]         step_reg;
    logic               neg_reg;
    logic signed [23:0] f_reg;
    logic               last_reg;
    logic signed [47:0] accr_reg, acci_reg;
    logic               sat_reg;
    logic               ov_reg;
    sas_out_t           ob_reg;

    logic [62:0]        mq, qm;
    logic signed [35:0] zw, zf;
    logic               negw;
    logic signed [33:0] xs, ys;
    logic signed [35:0] at;
    logic signed [24:0] cq, sq;
    logic signed [48:0] sr, si, pr, pi;
    logic signed [47:0] nr, ni;
    logic               satr, sati;
    logic               take, fin;

    assign take = state_reg == BK_IDLE && job_valid;
    assign fin  = state_reg == BK_ACC && (!last_reg || !ov_reg || out_ready);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (job_valid) state_next = BK_MUL;
            BK_MUL:  state_next = BK_QM;
            BK_QM:   state_next = BK_WRAP;
            BK_WRAP: state_next = BK_ROT;
            BK_ROT:  if (step_reg == 5'(CORDIC_STEPS-1)) state_next = BK_ACC;
            BK_ACC:  if (fin) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        job_ready = state_reg == BK_IDLE;
    end

    // Reduce the biased phase modulo two pi: estimate the turns from the top
    // bits by reciprocal multiply, which undershoots by at most one turn, then
    // subtract that many turns; the fold below removes the last one.
    assign mq = r_reg[62:32] * RECIP_Q72;
    assign qm = qe_reg * TWO_PI_Q38[40:0];

    // Fold to [-pi/2, pi/2]
    always_comb begin
        logic [62:0] rp;
        rp = (r_reg >= 63'(TWO_PI_Q38)) ? r_reg - 63'(TWO_PI_Q38) : r_reg;
        zw = 36'(rp >> 8);
        if (zw > PI_Q30) zw = zw - TWO_PI_Q30;
        negw = 1'b0;
        zf = zw;
        if (zw > HALF_PI_Q30) begin
            zf = zw - PI_Q30; negw = 1'b1;
        end else if (zw < -HALF_PI_Q30) begin
            zf = zw + PI_Q30; negw = 1'b1;
        end
    end

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign at = 36'(atan_q30(step_reg));

    // Round to Q1.22 and clamp
    function automatic logic signed [24:0] to_q22(input logic signed [33:0] v, input logic n);
        logic signed [34:0] w, r;
        w = n ? -35'(v) : 35'(v);
        r = (w + 35'sd128) >>> 8;
        if (r > 35'(TRIG_ONE)) r = 35'(TRIG_ONE);
        if (r < -35'(TRIG_ONE)) r = -35'(TRIG_ONE);
        to_q22 = 25'(r);
    endfunction

    assign cq = to_q22(x_reg, neg_reg);
    assign sq = to_q22(y_reg, neg_reg);
    assign pr = 49'(f_reg * cq);
    assign pi = 49'(f_reg * sq);
    assign sr = 49'(accr_reg) + pr;
    assign si = 49'(acci_reg) + pi;

    always_comb begin
        satr = 1'b0; sati = 1'b0;
        nr = sr[47:0]; ni = si[47:0];
        if (sr > 49'(ACC_MAX)) begin nr = ACC_MAX; satr = 1'b1; end
        if (sr < 49'(ACC_MIN)) begin nr = ACC_MIN; satr = 1'b1; end
        if (si > 49'(ACC_MAX)) begin ni = ACC_MAX; sati = 1'b1; end
        if (si < 49'(ACC_MIN)) begin ni = ACC_MIN; sati = 1'b1; end
    end

    // Advance the sequencer and accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            accr_reg  <= '0;
            acci_reg  <= '0;
            sat_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fin && last_reg) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
            if (fin) begin
                if (last_reg) begin
                    ob_reg.amp_real  <= nr;
                    ob_reg.amp_imag  <= ni;
                    ob_reg.saturated <= sat_reg | satr | sati;
                    accr_reg <= '0;
                    acci_reg <= '0;
                    sat_reg  <= 1'b0;
                end else begin
                    accr_reg <= nr;
                    acci_reg <= ni;
                    sat_reg  <= sat_reg | satr | sati;
                end
            end
        end
        if (take) begin
            r_reg    <= 63'(job_word.phase + 66'(PHASE_BIAS));
            f_reg    <= job_word.factor;
            last_reg <= job_word.last;
        end
        if (state_reg == BK_MUL) begin
            qe_reg <= mq[62:40];
        end
        if (state_reg == BK_QM) begin
            r_reg <= r_reg - qm;
        end
        if (state_reg == BK_WRAP) begin
            z_reg    <= zf;
            neg_reg  <= negw;
            x_reg    <= CORDIC_K_Q30;
            y_reg    <= '0;
            step_reg <= '0;
        end
        if (state_reg == BK_ROT) begin
            if (!z_reg[35]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            step_reg <= step_reg + 5'd1;
        end
    end

    assign out_valid = ov_reg;
    assign out_word  = ob_reg;

`ifndef NO_ASSERTIONS
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> state_reg == BK_MUL) else $error("take outside idle");
    a_rot_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_WRAP |=> step_reg == 5'd0) else $error("step not cleared");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && !out_ready |=> ov_reg) else $error("result dropped");
`endif

endmodule

/* design/scattering_amplitude_sum_top.sv */
// Structure-factor sum: one atom per input word. A two-stage front end forms
// q.r and queues it; the back end reduces the phase modulo 2pi (it takes the
// word, forms a reciprocal-multiply turn count, subtracts it, then folds), runs
// a 30-step CORDIC on one shared rotator and accumulates, taking no new word
// until that is done, so the CORDIC steps set most of its time per atom.
// The front accepts a word per cycle until the queue fills. A result word
// appears after the atom marked last and waits in an output register; while
// it is unaccepted, the next last atom stalls the back end.
module scattering_amplitude_sum_top
    import sas_pkg::*;
#(
    parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  sas_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output sas_out_t    m_data
);

    logic signed [31:0] qx_reg, qy_reg, qz_reg;
    logic               jv, jr, bv, br;
    sas_job_t           jw, bw;

    assign pready = 1'b1;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg <= '0; qy_reg <= '0; qz_reg <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_Q_X: qx_reg <= pwdata;
                REG_Q_Y: qy_reg <= pwdata;
                REG_Q_Z: qz_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_Q_X: prdata = qx_reg;
            REG_Q_Y: prdata = qy_reg;
            REG_Q_Z: prdata = qz_reg;
            default: prdata = '0;
        endcase
    end

    sas_front u_front (
        .aclk, .aresetn, .q_x(qx_reg), .q_y(qy_reg), .q_z(qz_reg),
        .in_valid(s_valid), .in_ready(s_ready), .in_word(s_data),
        .job_valid(jv), .job_ready(jr), .job_word(jw)
    );

    sas_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk, .aresetn, .wr_valid(jv), .wr_ready(jr), .wr_word(jw),
        .rd_valid(bv), .rd_ready(br), .rd_word(bw)
    );

    sas_back u_back (
        .aclk, .aresetn, .job_valid(bv), .job_ready(br), .job_word(bw),
        .out_valid(m_valid), .out_ready(m_ready), .out_word(m_data)
    );

endmodule

/* tb/scattering_amplitude_sum_top_tb.sv */
module scattering_amplitude_sum_top_tb;
    import sas_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    sas_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    sas_out_t    m_data;

    // Predictor state and configuration
    logic signed [31:0] q_vec [3];
    logic signed [47:0] sum_real;
    logic signed [47:0] sum_imag;
    logic               sum_sat;

    sas_out_t amp_queue [$];
    int       mismatch_count;
    int       frame_count;
    int       atom_count;
    longint   cycle_count;

    // Random gaps drawn from 0 to 18, with a gap-free quiet stretch now and then
    bit       quiet_mode;

    scattering_amplitude_sum_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Floor shift for signed values
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint round_trig(input longint v);
        longint r;
        r = floor_shift(v + 128, 8);
        if (r > 64'sd4194304) r = 64'sd4194304;
        if (r < -64'sd4194304) r = -64'sd4194304;
        return r;
    endfunction

    function automatic longint clamp_acc(input longint acc, input longint add,
                                         inout logic flag);
        longint r;
        r = acc + add;
        if (r > 64'sh7FFF_FFFF_FFFF) begin
            flag = 1'b1;
            return 64'sh7FFF_FFFF_FFFF;
        end
        if (r < -64'sh8000_0000_0000) begin
            flag = 1'b1;
            return -64'sh8000_0000_0000;
        end
        return r;
    endfunction

    // Rotate K by the wrapped phase and return cosine and sine in Q1.22
    task automatic phase_to_trig(input longint phase, output longint cos_v,
                                 output longint sin_v);
        longint r, z, x, y, xn;
        longint angle [30];
        bit     flip;
        angle = '{843314856, 497837829, 263043836, 133525158, 67021686,
                  33543515, 16775850, 8388437, 4194282, 2097149,
                  1048575, 524287, 262143, 131071, 65535,
                  32767, 16383, 8191, 4095, 2047,
                  1023, 511, 255, 127, 63, 31, 15, 7, 3, 1};
        flip = 1'b0;
        r = phase % 64'sd1727108826179;
        if (r < 0) r += 64'sd1727108826179;
        z = r >>> 8;
        if (z > 64'sd3373259426) z -= 64'sd6746518852;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z -= angle[i];
            end else begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z += angle[i];
            end
            x = xn;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_v = round_trig(x);
        sin_v = round_trig(y);
    endtask

    // Fold one atom into the running amplitude; queue the result on frame end
    task automatic predict_atom(input sas_in_t atom);
        longint   phase, c, s, f, ar, ai;
        logic     flag;
        sas_out_t amp;
        phase = floor_shift(longint'(atom.pos_x) * longint'(q_vec[0]), 2)
              + floor_shift(longint'(atom.pos_y) * longint'(q_vec[1]), 2)
              + floor_shift(longint'(atom.pos_z) * longint'(q_vec[2]), 2);
        phase_to_trig(phase, c, s);
        f    = longint'(atom.scatter_factor);
        flag = sum_sat;
        ar   = clamp_acc(longint'(sum_real), f * c, flag);
        ai   = clamp_acc(longint'(sum_imag), f * s, flag);
        sum_real = ar[47:0];
        sum_imag = ai[47:0];
        sum_sat  = flag;
        if (atom.last_atom) begin
            amp.amp_real  = sum_real;
            amp.amp_imag  = sum_imag;
            amp.saturated = sum_sat;
            amp_queue.insert(amp_queue.size(), amp);
            sum_real = '0;
            sum_imag = '0;
            sum_sat  = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    function automatic int draw_gap();
        if (quiet_mode) return 0;
        return $urandom_range(0, 18);
    endfunction

    // Send one atom word, holding valid until accepted; valid stays up when
    // the next word follows with no gap
    task automatic send_atom(input sas_in_t atom);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= atom;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_atom(atom);
        atom_count++;
        if (atom.last_atom) frame_count++;
    endtask

    // Setup then access cycle; the caller drops the select after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx <= REG_Q_Z) q_vec[idx] = value;
    endtask

    // Drop valid, drain all expected words, then let the back end settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (amp_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_q(input logic [31:0] qx, input logic [31:0] qy,
                         input logic [31:0] qz);
        wait_idle();
        write_reg(REG_Q_X, qx);
        write_reg(REG_Q_Y, qy);
        write_reg(REG_Q_Z, qz);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic sas_in_t make_atom(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic [23:0] f,
                                          input logic last);
        sas_in_t a;
        a.pos_x = x;
        a.pos_y = y;
        a.pos_z = z;
        a.scatter_factor = f;
        a.last_atom = last;
        return a;
    endfunction

    function automatic sas_in_t random_atom(input logic last);
        return make_atom($urandom, $urandom, $urandom, 24'($urandom), last);
    endfunction

    // Extremes of position and factor under a mid-range q, with zero phase too
    task automatic test_field_extremes();
        set_q(32'h0100_0000, 32'hFF00_0000, 32'h0080_0000);
        send_atom(make_atom(32'h0, 32'h0, 32'h0, 24'h7FFFFF, 1'b1));
        send_atom(make_atom(32'h7FFFFFFF, 32'h80000000, 32'h0, 24'h800000, 1'b0));
        send_atom(make_atom(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 24'h7FFFFF, 1'b1));
        send_atom(make_atom(32'h0001_0000, 32'h0, 32'h0, 24'h010000, 1'b1));
        send_atom(make_atom(32'hFFFF_0000, 32'h0003_0000, 32'h0, 24'hFFFFFF, 1'b1));
    endtask

    // Extreme q values, every register at both ends
    task automatic test_q_extremes();
        set_q(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_atom(make_atom(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 24'h7FFFFF, 1'b1));
        send_atom(make_atom(32'h12345678, 32'h9ABCDEF0, 32'h0, 24'h400000, 1'b1));
        set_q(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_atom(make_atom(32'h80000000, 32'h80000000, 32'h80000000, 24'h800000, 1'b1));
        set_q(32'h0, 32'h0, 32'h0);
        send_atom(make_atom(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 24'h123456, 1'b1));
    endtask

    // Long frames of full-scale factors drive the real accumulator into clamp, then both
    task automatic test_saturation();
        set_q(32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 12; i++)
            send_atom(make_atom(32'h0, 32'h0, 32'h0, 24'h7FFFFF, i == 11));
        send_atom(make_atom(32'h0, 32'h0, 32'h0, 24'h000100, 1'b1));
        set_q(32'h0192_1FB5, 32'h0, 32'h0);
        for (int i = 0; i < 12; i++)
            send_atom(make_atom(32'h0000_8000, 32'h0, 32'h0, 24'h800000, i == 11));
    endtask

    // Random frames of 1..12 atoms under several random q settings
    task automatic test_random_frames();
        int len;
        int sent;
        sent = 0;
        for (int phase_idx = 0; phase_idx < 5; phase_idx++) begin
            set_q($urandom, $urandom, $urandom);
            while (sent < (phase_idx + 1) * 80) begin
                quiet_mode = ($urandom_range(0, 5) == 0);
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    send_atom(random_atom(k == len - 1));
                    sent++;
                end
            end
        end
        quiet_mode = 1'b0;
    endtask

    // Check each result word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (amp_queue.size() == 0) begin
                report_mismatch("unexpected word", m_data.amp_real, 48'h0);
            end else begin
                if (m_data.amp_real !== amp_queue[0].amp_real)
                    report_mismatch("amp_real", m_data.amp_real, amp_queue[0].amp_real);
                if (m_data.amp_imag !== amp_queue[0].amp_imag)
                    report_mismatch("amp_imag", m_data.amp_imag, amp_queue[0].amp_imag);
                if (m_data.saturated !== amp_queue[0].saturated)
                    report_mismatch("saturated", 48'(m_data.saturated),
                                    48'(amp_queue[0].saturated));
                void'(amp_queue.pop_front());
            end
        end
    end

    // Stall the result side with a fresh random hold-off after each word
    initial begin : result_stall
        int hold;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            hold = draw_gap();
            if (hold == 0) begin
                m_ready <= 1'b1;
                @(posedge aclk);
                while (!m_valid) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
                m_ready <= 1'b1;
                @(posedge aclk);
                while (!m_valid) @(posedge aclk);
            end
        end
    end

    // Abort on a run that never finishes
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        frame_count    = 0;
        atom_count     = 0;
        cycle_count    = 0;
        quiet_mode     = 1'b0;
        q_vec          = '{32'sd0, 32'sd0, 32'sd0};
        sum_real       = '0;
        sum_imag       = '0;
        sum_sat        = 1'b0;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_data         = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_q_extremes();
        test_saturation();
        test_random_frames();

        wait_idle();
        $display("covered %0d atoms in %0d frames over several q settings,",
                 atom_count, frame_count);
        $display("including extremes of every field and saturated frames");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* scattering_amplitude_sum_top.f */
design/sas_pkg.sv
design/sas_front.sv
design/sas_fifo.sv
design/sas_back.sv
design/scattering_amplitude_sum_top.sv
tb/scattering_amplitude_sum_top_tb.sv
